// File: rtl/olide_pkg.sv
package olide_pkg;

  localparam int POS_W = 7;
  localparam int VAL_W = 8;

  typedef enum logic [1:0] {
    ACT_READ   = 2'd0,
    ACT_FIND   = 2'd1,
    ACT_INSERT = 2'd2,
    ACT_DELETE = 2'd3
  } action_t;

  // Broadcast to every cell: shift of the list from cmd.pos on, with the inserted value.
  typedef struct packed {
    logic             shift_up;
    logic             shift_down;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] value;
  } cmd_t;

  // Lookup token walking the chain, one cell per cycle.
  typedef struct packed {
    logic             valid;
    action_t          act;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] value;
    logic             ok;
    logic [VAL_W-1:0] item;
    logic [POS_W-1:0] found_at;
  } token_t;

endpackage

// File: rtl/olide_cell.sv
module olide_cell #(
  parameter int INDEX = 0,
  parameter int CW    = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  olide_pkg::cmd_t            cmd,
  input  logic [CW-1:0]              fill,
  input  olide_pkg::token_t          tok_in,
  input  logic [olide_pkg::VAL_W-1:0] left,
  input  logic [olide_pkg::VAL_W-1:0] right,
  output logic [olide_pkg::VAL_W-1:0] entry,
  output olide_pkg::token_t          tok_out
);

  localparam int PW = olide_pkg::POS_W;
  localparam logic [CW-1:0] SLOT    = CW'(INDEX);
  localparam logic [CW-1:0] SLOT_P1 = CW'(INDEX + 1);

  logic [CW-1:0]     cmd_pos;
  logic [CW-1:0]     tok_pos;
  logic              in_list;
  olide_pkg::token_t tok_next;

  assign cmd_pos = CW'(cmd.pos);
  assign tok_pos = CW'(tok_in.pos);
  assign in_list = (SLOT < fill);

  // insert: slots at or past pos take the left neighbor, slot pos-1 takes the value
  // delete: slots from pos-1 on take the right neighbor
  always_ff @(posedge clk) begin
    if (cmd.shift_up) begin
      if (SLOT_P1 > cmd_pos) begin
        entry <= left;
      end else if (SLOT_P1 == cmd_pos) begin
        entry <= cmd.value;
      end
    end else if (cmd.shift_down && (SLOT_P1 >= cmd_pos)) begin
      entry <= right;
    end
  end

  always_comb begin
    tok_next = tok_in;
    unique case (tok_in.act) inside
      olide_pkg::ACT_READ, olide_pkg::ACT_DELETE: begin
        if (in_list && (SLOT_P1 == tok_pos)) begin
          tok_next.ok   = 1'b1;
          tok_next.item = entry;
        end
      end
      olide_pkg::ACT_FIND: begin
        if (!tok_in.ok && in_list && (entry == tok_in.value)) begin
          tok_next.ok       = 1'b1;
          tok_next.found_at = PW'(INDEX + 1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

// File: rtl/ordered_list_insert_delete_engine.sv
// Ordered list of bytes held in a chain of CAPACITY cells, one entry per cell.
//
// Input channel s_axis: one request item per handshake. s_axis_tuser carries
// the action (read, find, insert, delete); s_axis_tdata carries position and
// value. Output channel m_axis: exactly one result item per request, in order.
//
// Insert: every cell loads its left neighbor, the new value or holds, all in
// the accepting cycle. The result shows in the cycle after accept, and the
// next request can be taken then while the receiver is ready (one item per cycle).
// Read, find, delete: a token enters cell 0 and steps one cell per cycle down
// the chain, picking up the addressed entry or the first match. From the last
// cell it is parked in a holding register, then moves to the result register
// once that is free; a delete shifts the cells down at that same edge. The
// next item is taken no earlier than the cycle the result shows, so a new
// request waits until the last lookup is through the chain.
// Reset clears the length and the token chain; entry contents are not reset.
// A stalled receiver holds the result register; a waiting lookup result
// stays parked until the output register frees up.
module ordered_list_insert_delete_engine #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [6:0] position, [14:7] value, [15] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [0] ok, [8:1] item, [15:9] found_at,
                                      // [22:16] count, [23] zero
);

  localparam int PW     = olide_pkg::POS_W;
  localparam int VW     = olide_pkg::VAL_W;
  localparam int FILL_W = $clog2(CAPACITY + 1);
  localparam int CW     = ((FILL_W > PW) ? FILL_W : PW) + 1;

  // request fields
  olide_pkg::action_t s_act;
  logic [PW-1:0]      s_pos;
  logic [VW-1:0]      s_value;

  // list state and control
  logic [FILL_W-1:0]  fill;
  logic [CW-1:0]      fill_e;
  logic [CW-1:0]      pos_e;
  logic               busy;
  logic               pend_valid;
  olide_pkg::token_t  pend;
  logic               accept;
  logic               launch;
  logic               ins_ok;
  logic               pend_move;
  logic               del_shift;
  olide_pkg::cmd_t    cmd;

  // result register
  logic               out_valid;
  logic               out_ok;
  logic [VW-1:0]      out_item;
  logic [PW-1:0]      out_found;
  logic [PW-1:0]      out_count;

  // cell chain
  logic [VW-1:0]      entries [CAPACITY];
  olide_pkg::token_t  tok     [CAPACITY+1];
  logic [CAPACITY:0]  tok_valid;

  assign s_act   = olide_pkg::action_t'(s_axis_tuser);
  assign s_pos   = s_axis_tdata[PW-1:0];
  assign s_value = s_axis_tdata[PW+VW-1:PW];

  assign fill_e = CW'(fill);
  assign pos_e  = CW'(s_pos);

  // Only one request in flight; a new one waits for the output slot.
  assign s_axis_tready = !busy && (!out_valid || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign launch        = accept && (s_act != olide_pkg::ACT_INSERT);

  // Insert needs room and a position in 1..fill+1.
  assign ins_ok = (fill_e < CW'(CAPACITY)) && (pos_e != '0) && (pos_e <= fill_e + 1'b1);

  assign pend_move = pend_valid && (!out_valid || m_axis_tready);
  assign del_shift = pend_move && (pend.act == olide_pkg::ACT_DELETE) && pend.ok;

  always_comb begin
    cmd.shift_up   = accept && (s_act == olide_pkg::ACT_INSERT) && ins_ok;
    cmd.shift_down = del_shift;
    cmd.pos        = del_shift ? pend.pos : s_pos;
    cmd.value      = s_value;
  end

  // Token entering the head of the chain.
  always_comb begin
    tok[0]          = '0;
    tok[0].valid    = launch;
    tok[0].act      = s_act;
    tok[0].pos      = s_pos;
    tok[0].value    = s_value;
  end

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    olide_cell #(
      .INDEX (k),
      .CW    (CW)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .cmd     (cmd),
      .fill    (fill_e),
      .tok_in  (tok[k]),
      .left    ((k == 0) ? entries[k] : entries[(k == 0) ? 0 : k-1]),
      .right   ((k == CAPACITY-1) ? entries[k] : entries[(k == CAPACITY-1) ? k : k+1]),
      .entry   (entries[k]),
      .tok_out (tok[k+1])
    );
  end

  for (genvar k = 0; k <= CAPACITY; k++) begin : g_tv
    assign tok_valid[k] = tok[k].valid;
  end

  // Control: busy from lookup launch until its result moves to the output.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (launch) begin
        busy <= 1'b1;
      end else if (pend_move) begin
        busy <= 1'b0;
      end
      if (tok[CAPACITY].valid) begin
        pend_valid <= 1'b1;
      end else if (pend_move) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok[CAPACITY].valid) begin
      pend <= tok[CAPACITY];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.shift_up) begin
      fill <= fill + 1'b1;
    end else if (cmd.shift_down) begin
      fill <= fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && (s_act == olide_pkg::ACT_INSERT)) begin
      out_valid <= 1'b1;
    end else if (pend_move) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (s_act == olide_pkg::ACT_INSERT)) begin
      out_ok    <= ins_ok;
      out_item  <= '0;
      out_found <= '0;
      out_count <= ins_ok ? PW'(fill_e + 1'b1) : PW'(fill_e);
    end else if (pend_move) begin
      out_ok    <= pend.ok;
      out_item  <= pend.item;
      out_found <= pend.found_at;
      out_count <= del_shift ? PW'(fill_e - 1'b1) : PW'(fill_e);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_count, out_found, out_item, out_ok};

`ifndef SYNTHESIS
  // at most one lookup token in the chain
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_valid))
    else $error("more than one token in the cell chain");

  a_exit_busy: assert property (@(posedge clk) disable iff (rst)
    tok[CAPACITY].valid |-> (busy && !pend_valid))
    else $error("token left the chain while idle or with a parked result");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill_e <= CW'(CAPACITY))
    else $error("list length beyond capacity");

  a_ins_grow: assert property (@(posedge clk) disable iff (rst)
    cmd.shift_up |=> (fill == FILL_W'($past(fill) + 1'b1)))
    else $error("insert did not grow the list");
`endif

endmodule
